// ===== hdl/ops_pkg.sv =====
package ops_pkg;

  localparam int CONFIRM_COUNT = 3;
  localparam int LEVEL_W       = 8;
  localparam int ADDR_W        = 4;
  localparam int DATA_W        = 32;

  localparam logic [LEVEL_W-1:0] RESET_CODE      = 8'd120;
  localparam logic [LEVEL_W-1:0] RESET_THRESHOLD = 8'd5;

  typedef enum logic [1:0] {
    REG_NO_TARGET = 2'd0,
    REG_JUMP_TH   = 2'd1,
    REG_JUMP_EN   = 2'd2,
    REG_NONE      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] no_target_code;
    logic [LEVEL_W-1:0] jump_threshold;
    logic               jump_enable;
  } cfg_t;

  // Window summary passed from the newest cell toward the oldest one
  typedef struct packed {
    logic               all_real;
    logic               all_none;
    logic               found;
    logic [LEVEL_W-1:0] level;
  } chain_t;

endpackage

// ===== hdl/ops_if.sv =====
interface ops_in_if
  import ops_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] sample_level;

  modport source (output valid, output sample_level, input ready);
  modport sink   (input valid, input sample_level, output ready);
endinterface

interface ops_out_if
  import ops_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] filtered_level;
  logic               target_present;

  modport source (output valid, output filtered_level, output target_present, input ready);
  modport sink   (input valid, input filtered_level, input target_present, output ready);
endinterface

// ===== hdl/obstacle_presence_filter.sv =====
// Obstacle presence filter.
// in_ch carries one 8-bit distance level per item; out_ch returns exactly one
// item per input item: the qualified level (or the no-target code) and the
// presence flag after that sample. Both channels use valid/ready; an item
// moves when both are high.
// out_ch.valid is registered: an accepted item passes the window stage and
// then the output register before out_ch.valid rises.
// Throughput is one item per cycle while out_ch does not stall: the sample
// window is a row of cells that shift on every accepted item, and the
// presence/jump decision runs once per item on the registered window.
// When out_ch stalls, the result stays in the output register and one more
// item can sit in the window stage; after that in_ch.ready drops.
// Synchronous active-low reset sets the window and output history to the
// no-target code 120, clears presence and jump state, and loads the register
// defaults (code 120, threshold 5, suppression on).
// Registers on the cfg_ APB port: 0x0 no-target code, 0x4 jump threshold,
// 0x8 jump suppression enable. Write only while the block is idle.
module obstacle_presence_filter
  import ops_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  ops_in_if.sink            in_ch,
  ops_out_if.source         out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  cfg_t     cfg_r;
  reg_idx_t widx;
  logic     cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign widx       = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.no_target_code <= RESET_CODE;
      cfg_r.jump_threshold <= RESET_THRESHOLD;
      cfg_r.jump_enable    <= 1'b1;
    end else if (cfg_wr) begin
      case (widx)
        REG_NO_TARGET: cfg_r.no_target_code <= cfg_pwdata[LEVEL_W-1:0];
        REG_JUMP_TH:   cfg_r.jump_threshold <= cfg_pwdata[LEVEL_W-1:0];
        REG_JUMP_EN:   cfg_r.jump_enable    <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_NO_TARGET: cfg_prdata = {{(DATA_W-LEVEL_W){1'b0}}, cfg_r.no_target_code};
      REG_JUMP_TH:   cfg_prdata = {{(DATA_W-LEVEL_W){1'b0}}, cfg_r.jump_threshold};
      REG_JUMP_EN:   cfg_prdata = {{(DATA_W-1){1'b0}}, cfg_r.jump_enable};
      default:       cfg_prdata = '0;
    endcase
  end

  // pipeline control
  logic s1_v_r;
  logic out_v_r;
  logic s1_adv;
  logic in_acc;

  assign s1_adv      = ~out_v_r | out_ch.ready;
  assign in_ch.ready = ~s1_v_r | s1_adv;
  assign in_acc      = in_ch.valid & in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  // window cells, index CONFIRM_COUNT-1 holds the newest sample
  logic [LEVEL_W-1:0] cell_val [CONFIRM_COUNT];
  chain_t             chain    [CONFIRM_COUNT+1];

  assign chain[CONFIRM_COUNT] = '{all_real: 1'b1, all_none: 1'b1, found: 1'b0,
                                  level: cfg_r.no_target_code};

  for (genvar k = 0; k < CONFIRM_COUNT; k++) begin : g_cell
    logic [LEVEL_W-1:0] sin;
    if (k == CONFIRM_COUNT - 1) begin : g_top
      assign sin = in_ch.sample_level;
    end else begin : g_mid
      assign sin = cell_val[k+1];
    end
    ops_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift_en  (in_acc),
      .shift_in  (sin),
      .code      (cfg_r.no_target_code),
      .chain_in  (chain[k+1]),
      .value     (cell_val[k]),
      .chain_out (chain[k])
    );
  end

  logic [LEVEL_W-1:0] res_level;
  logic               res_present;

  ops_judge u_judge (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (s1_v_r & s1_adv),
    .cfg         (cfg_r),
    .chain       (chain[0]),
    .newest      (cell_val[CONFIRM_COUNT-1]),
    .res_level   (res_level),
    .res_present (res_present)
  );

  logic [LEVEL_W-1:0] out_level_r;
  logic               out_present_r;

  always_ff @(posedge clk) begin
    if (s1_v_r && s1_adv) begin
      out_level_r   <= res_level;
      out_present_r <= res_present;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.filtered_level = out_level_r;
  assign out_ch.target_present = out_present_r;

endmodule

// ===== hdl/ops_cell.sv =====
module ops_cell
  import ops_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               shift_en,
  input  logic [LEVEL_W-1:0] shift_in,
  input  logic [LEVEL_W-1:0] code,
  input  chain_t             chain_in,
  output logic [LEVEL_W-1:0] value,
  output chain_t             chain_out
);

  logic [LEVEL_W-1:0] value_r;
  logic               is_real;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= RESET_CODE;
    end else if (shift_en) begin
      value_r <= shift_in;
    end
  end

  assign value   = value_r;
  assign is_real = (value_r != code);

  always_comb begin
    chain_out.all_real = chain_in.all_real & is_real;
    chain_out.all_none = chain_in.all_none & ~is_real;
    chain_out.found    = chain_in.found | is_real;
    // first real sample seen from the newest end wins
    chain_out.level    = (!chain_in.found && is_real) ? value_r : chain_in.level;
  end

endmodule

// ===== hdl/ops_judge.sv =====
module ops_judge
  import ops_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  cfg_t               cfg,
  input  chain_t             chain,
  input  logic [LEVEL_W-1:0] newest,
  output logic [LEVEL_W-1:0] res_level,
  output logic               res_present
);

  logic               presence_r, presence_nxt;
  logic               jump_r, jump_nxt;
  logic [LEVEL_W-1:0] hist_r, hist_nxt;
  logic [LEVEL_W-1:0] cand;
  logic [LEVEL_W-1:0] diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      presence_r <= 1'b0;
      jump_r     <= 1'b0;
      hist_r     <= RESET_CODE;
    end else if (step) begin
      presence_r <= presence_nxt;
      jump_r     <= jump_nxt;
      hist_r     <= hist_nxt;
    end
  end

  always_comb begin
    presence_nxt = presence_r;
    cand         = cfg.no_target_code;
    if (!presence_r) begin
      if (chain.all_real) begin
        presence_nxt = 1'b1;
        cand         = newest;
      end
    end else if (chain.all_none) begin
      presence_nxt = 1'b0;
    end else begin
      cand = chain.level;
    end

    diff = (cand >= hist_r) ? (cand - hist_r) : (hist_r - cand);

    jump_nxt  = jump_r;
    hist_nxt  = hist_r;
    res_level = cand;
    if (presence_nxt && cfg.jump_enable) begin
      hist_nxt = cand;
      if (!jump_r) begin
        if (diff > cfg.jump_threshold) begin
          jump_nxt  = 1'b1;
          res_level = hist_r;
        end
      end else if (diff <= cfg.jump_threshold) begin
        jump_nxt = 1'b0;
      end
    end
    res_present = presence_nxt;
  end

endmodule
